// ----- rtl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Command and status codes and the controller/datapath interface types of
// the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int unsigned OCC_W = 5;

    typedef struct packed {
        logic load;
        logic finish;
        logic pop_read;
        logic pop_out;
    } t_dq_ctrl;

    typedef struct packed {
        logic is_push;
        logic is_full;
        logic is_empty;
        logic out_free;
    } t_dq_stat;

endpackage

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// A push, or a pop from an empty queue, passes from the command register to
// the result register; a pop that removes an entry also passes the registered
// store read. No new command beat is taken until the last result is registered,
// as set by the controller sequence; a stalled output holds the sequence.
// Reset (synchronous, active low) empties the queue; the store is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue
// Circular double-ended queue of signed 32-bit words: push or pop at either
// end, one result beat per command beat.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [1:0]              i_command,
    input  wire logic signed [31:0]      i_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [31:0]           o_popped_value,
    output logic [1:0]                   o_status,
    output logic [dq_pkg::OCC_W-1:0]     o_occupancy
);
    import dq_pkg::*;

    t_dq_ctrl ctrl;
    t_dq_stat stat;

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

endmodule

`default_nettype wire

// ----- rtl/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer of the queue: capture a command beat, execute it, and for a
// pop that removes an entry wait for the registered store read.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  dq_pkg::t_dq_stat      i_stat,
    output dq_pkg::t_dq_ctrl      o_ctrl
);
    import dq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    if (i_stat.is_push || i_stat.is_empty) begin
                        o_ctrl.finish = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_ctrl.pop_read = 1'b1;
                        n_state         = S_READ;
                    end
                end
            end
            S_READ: begin
                if (i_stat.out_free) begin
                    o_ctrl.pop_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dq_datapath.sv -----
// ----------------------------------------------------------------------------
// dq_datapath
// Ring store, head and tail indices, entry count, command register and
// result register of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_datapath #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [1:0]                i_command,
    input  wire logic signed [31:0]        i_value,
    input  dq_pkg::t_dq_ctrl               i_ctrl,
    output dq_pkg::t_dq_stat               o_stat,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [31:0]             o_popped_value,
    output logic [1:0]                     o_status,
    output logic [dq_pkg::OCC_W-1:0]       o_occupancy
);
    import dq_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [31:0]   r_store [DEPTH];
    logic [31:0]   r_rd_data;
    logic [1:0]    r_cmd;
    logic [31:0]   r_val;
    logic [IW-1:0] r_head;
    logic [IW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic          r_out_valid;
    logic [31:0]   r_out_value;
    logic [1:0]    r_out_status;
    logic [OCC_W-1:0] r_out_occ;

    logic [IW-1:0] head_dn;
    logic [IW-1:0] head_up;
    logic [IW-1:0] tail_dn;
    logic [IW-1:0] tail_up;
    logic          is_front;
    logic          do_write;
    logic [IW-1:0] addr;

    assign head_dn  = (r_head == '0) ? LAST : r_head - 1'b1;
    assign head_up  = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign tail_dn  = (r_tail == '0) ? LAST : r_tail - 1'b1;
    assign tail_up  = (r_tail == LAST) ? '0 : r_tail + 1'b1;
    assign is_front = (r_cmd == CMD_PUSH_FRONT) || (r_cmd == CMD_POP_FRONT);

    assign o_stat.is_push  = (r_cmd == CMD_PUSH_FRONT) || (r_cmd == CMD_PUSH_BACK);
    assign o_stat.is_full  = (r_count == FULL_COUNT);
    assign o_stat.is_empty = (r_count == '0);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign do_write = i_ctrl.finish && o_stat.is_push && !o_stat.is_full;

    always_comb begin
        if (o_stat.is_push) begin
            addr = is_front ? head_dn : r_tail;
        end else begin
            addr = is_front ? r_head : tail_dn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_store[addr] <= r_val;
        end
        if (i_ctrl.pop_read) begin
            r_rd_data <= r_store[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (do_write) begin
            if (is_front) begin
                r_head <= head_dn;
            end else begin
                r_tail <= tail_up;
            end
            r_count <= r_count + 1'b1;
        end else if (i_ctrl.pop_read) begin
            if (is_front) begin
                r_head <= head_up;
            end else begin
                r_tail <= tail_dn;
            end
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.finish || i_ctrl.pop_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.finish) begin
            if (o_stat.is_push) begin
                r_out_value  <= '0;
                r_out_status <= o_stat.is_full ? ST_FULL : ST_OK;
                r_out_occ    <= o_stat.is_full ? OCC_W'(r_count) : OCC_W'(r_count + 1'b1);
            end else begin
                r_out_value  <= '1;
                r_out_status <= ST_EMPTY;
                r_out_occ    <= OCC_W'(r_count);
            end
        end else if (i_ctrl.pop_out) begin
            r_out_value  <= r_rd_data;
            r_out_status <= ST_OK;
            r_out_occ    <= OCC_W'(r_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_occupancy    = r_out_occ;

endmodule

`default_nettype wire
